>>> rtl/core/mcso_pkg.sv
// Shared constants, types and slot helpers for the multicolor cell slot optimizer.
// Standalone package; used by the channel interfaces, the top level and the checker.
package mcso_pkg;

	localparam int unsigned PIXELS = 32;
	localparam int unsigned SLOT_W = 2;
	localparam int unsigned BM_W   = PIXELS * SLOT_W;
	localparam int unsigned NIB_W  = 4;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [BM_W-1:0]   bitmap_t;
	typedef logic [NIB_W-1:0]  nibble_t;
	typedef logic [BYTE_W-1:0] byte_t;

	localparam slot_t SLOT_BG  = 2'd0;
	localparam slot_t SLOT_HI  = 2'd1;
	localparam slot_t SLOT_LO  = 2'd2;
	localparam slot_t SLOT_RAM = 2'd3;

	typedef enum logic [0:0] {
		REG_BACKGROUND_COLOR = 1'b0
	} reg_idx_t;

	typedef struct packed {
		slot_t map_hi;
		slot_t map_lo;
		slot_t map_ram;
	} slot_plan_t;

	function automatic logic slot_present(bitmap_t bm, slot_t v);
		logic hit;
		hit = 1'b0;
		for (int unsigned i = 0; i < PIXELS; i++) begin
			hit = hit | (bm[SLOT_W*i +: SLOT_W] == v);
		end
		return hit;
	endfunction

	function automatic bitmap_t slot_remap(bitmap_t bm, slot_plan_t plan);
		bitmap_t res;
		res = bm;
		for (int unsigned i = 0; i < PIXELS; i++) begin
			unique case (bm[SLOT_W*i +: SLOT_W])
				SLOT_BG:  res[SLOT_W*i +: SLOT_W] = SLOT_BG;
				SLOT_HI:  res[SLOT_W*i +: SLOT_W] = plan.map_hi;
				SLOT_LO:  res[SLOT_W*i +: SLOT_W] = plan.map_lo;
				SLOT_RAM: res[SLOT_W*i +: SLOT_W] = plan.map_ram;
				default:  res[SLOT_W*i +: SLOT_W] = SLOT_BG;
			endcase
		end
		return res;
	endfunction

endpackage

>>> rtl/core/mcso_in_if.sv
// Input cell channel: valid/ready handshake with bitmap, screen and color bytes.
// Depends on mcso_pkg for field types.
interface mcso_in_if;
	logic                valid;
	logic                ready;
	mcso_pkg::bitmap_t   cell_bitmap;
	mcso_pkg::byte_t     screen_byte;
	mcso_pkg::byte_t     color_byte;

	modport source (output valid, output cell_bitmap, output screen_byte, output color_byte,
		input ready);
	modport sink (input valid, input cell_bitmap, input screen_byte, input color_byte,
		output ready);
endinterface

>>> rtl/core/mcso_out_if.sv
// Result cell channel: valid/ready handshake with recoded bitmap, screen and color.
// Depends on mcso_pkg for field types.
interface mcso_out_if;
	logic                valid;
	logic                ready;
	mcso_pkg::bitmap_t   out_bitmap;
	mcso_pkg::byte_t     out_screen;
	mcso_pkg::byte_t     out_color;

	modport source (output valid, output out_bitmap, output out_screen, output out_color,
		input ready);
	modport sink (input valid, input out_bitmap, input out_screen, input out_color,
		output ready);
endinterface

>>> rtl/core/multicolor_cell_slot_optimizer.sv
// Top level of the multicolor cell slot optimizer: APB register and three-stage pipeline.
// Depends on mcso_pkg, mcso_in_if and mcso_out_if.
//
// One cell per clock cycle sustained while the output is not stalled. A result moves from its
// input transfer through the stage one, two and three registers and leaves from stage three.
// Stage one registers the cell together with each slot's keep flag (slot present and its
// color unlike the background), stage two resolves the slot moves and final colors, stage
// three recodes the 32 pixels. All stages advance together whenever the result register is
// empty or being taken, so in_ch.ready follows out_ch.ready combinationally. The background
// color sits at byte address 0 and must only be written while the pipeline is empty.
module multicolor_cell_slot_optimizer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mcso_pkg::APB_AW-1:0] paddr,
	input  logic [mcso_pkg::APB_DW-1:0] pwdata,
	output logic [mcso_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	mcso_in_if.sink                     in_ch,
	mcso_out_if.source                  out_ch
);

	mcso_pkg::byte_t    bg_q;
	mcso_pkg::reg_idx_t reg_idx;
	logic               reg_hit;

	logic               advance;

	logic               keep_hi, keep_lo, keep_ram;
	logic               valid_s1;
	mcso_pkg::bitmap_t  bm_s1;
	mcso_pkg::nibble_t  hi_s1, lo_s1;
	mcso_pkg::byte_t    ram_s1;
	logic               keep_hi_s1, keep_lo_s1, keep_ram_s1;

	logic               do_a, do_b, do_c, ram_after_a, lo_after_a, hi_after_b;
	mcso_pkg::nibble_t  hi0, lo0, hi_n, lo_n;
	mcso_pkg::byte_t    ram0, ram_n;
	mcso_pkg::slot_plan_t plan;

	logic               valid_s2;
	mcso_pkg::bitmap_t  bm_s2;
	mcso_pkg::slot_plan_t plan_s2;
	mcso_pkg::byte_t    screen_s2, color_s2;

	logic               valid_s3;
	mcso_pkg::bitmap_t  bm_s3;
	mcso_pkg::byte_t    screen_s3, color_s3;

	assign pready  = 1'b1;
	assign reg_idx = mcso_pkg::reg_idx_t'(paddr[2]);
	assign reg_hit = (paddr[mcso_pkg::APB_AW-1:2] == '0);

	always_comb begin
		prdata = '0;
		if (reg_hit && reg_idx == mcso_pkg::REG_BACKGROUND_COLOR) begin
			prdata = {{(mcso_pkg::APB_DW - mcso_pkg::BYTE_W){1'b0}}, bg_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit
				&& reg_idx == mcso_pkg::REG_BACKGROUND_COLOR) begin
			bg_q <= pwdata[mcso_pkg::BYTE_W-1:0];
		end
	end

	assign advance     = !valid_s3 || out_ch.ready;
	assign in_ch.ready = advance;

	assign keep_hi  = mcso_pkg::slot_present(in_ch.cell_bitmap, mcso_pkg::SLOT_HI)
		&& ({4'h0, in_ch.screen_byte[7:4]} != bg_q);
	assign keep_lo  = mcso_pkg::slot_present(in_ch.cell_bitmap, mcso_pkg::SLOT_LO)
		&& ({4'h0, in_ch.screen_byte[3:0]} != bg_q);
	assign keep_ram = mcso_pkg::slot_present(in_ch.cell_bitmap, mcso_pkg::SLOT_RAM)
		&& (in_ch.color_byte != bg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bm_s1       <= in_ch.cell_bitmap;
			hi_s1       <= in_ch.screen_byte[7:4];
			lo_s1       <= in_ch.screen_byte[3:0];
			ram_s1      <= in_ch.color_byte;
			keep_hi_s1  <= keep_hi;
			keep_lo_s1  <= keep_lo;
			keep_ram_s1 <= keep_ram;
		end
	end

	always_comb begin
		hi0  = keep_hi_s1  ? hi_s1  : '0;
		lo0  = keep_lo_s1  ? lo_s1  : '0;
		ram0 = keep_ram_s1 ? ram_s1 : '0;

		do_a        = !keep_ram_s1 && keep_lo_s1;
		ram_after_a = keep_ram_s1 || keep_lo_s1;
		lo_after_a  = keep_lo_s1 && keep_ram_s1;
		do_b        = !ram_after_a && keep_hi_s1;
		hi_after_b  = keep_hi_s1 && ram_after_a;
		do_c        = !lo_after_a && hi_after_b;

		priority if (!keep_hi_s1) plan.map_hi = mcso_pkg::SLOT_BG;
		else if (do_b)            plan.map_hi = mcso_pkg::SLOT_RAM;
		else if (do_c)            plan.map_hi = mcso_pkg::SLOT_LO;
		else                      plan.map_hi = mcso_pkg::SLOT_HI;

		priority if (!keep_lo_s1) plan.map_lo = mcso_pkg::SLOT_BG;
		else if (do_a)            plan.map_lo = mcso_pkg::SLOT_RAM;
		else                      plan.map_lo = mcso_pkg::SLOT_LO;

		plan.map_ram = keep_ram_s1 ? mcso_pkg::SLOT_RAM : mcso_pkg::SLOT_BG;

		priority if (do_a) ram_n = {4'h0, lo0};
		else if (do_b)     ram_n = {4'h0, hi0};
		else               ram_n = ram0;

		priority if (do_c) lo_n = hi0;
		else if (do_a)     lo_n = '0;
		else               lo_n = lo0;

		hi_n = (do_b || do_c) ? '0 : hi0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bm_s2     <= bm_s1;
			plan_s2   <= plan;
			screen_s2 <= {hi_n, lo_n};
			color_s2  <= ram_n;
			bm_s3     <= mcso_pkg::slot_remap(bm_s2, plan_s2);
			screen_s3 <= screen_s2;
			color_s3  <= color_s2;
		end
	end

	assign out_ch.valid      = valid_s3;
	assign out_ch.out_bitmap = bm_s3;
	assign out_ch.out_screen = screen_s3;
	assign out_ch.out_color  = color_s3;

endmodule

>>> rtl/core/mcso_checker.sv
// Port-level checker for multicolor_cell_slot_optimizer, attached by the bind below.
// Depends on mcso_pkg for slot codes and the presence helper.
module mcso_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [mcso_pkg::APB_AW-1:0] paddr,
	input logic [mcso_pkg::APB_DW-1:0] pwdata,
	input logic [mcso_pkg::APB_DW-1:0] prdata,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input mcso_pkg::bitmap_t           out_bitmap,
	input mcso_pkg::byte_t             out_screen,
	input mcso_pkg::byte_t             out_color
);

	logic has_hi, has_lo, has_ram, wr_bg;

	assign has_hi  = mcso_pkg::slot_present(out_bitmap, mcso_pkg::SLOT_HI);
	assign has_lo  = mcso_pkg::slot_present(out_bitmap, mcso_pkg::SLOT_LO);
	assign has_ram = mcso_pkg::slot_present(out_bitmap, mcso_pkg::SLOT_RAM);
	assign wr_bg   = psel && penable && pwrite && (paddr == '0);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("transfer did not reach the output in three cycles");

	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (has_hi || has_lo) |-> has_ram && (!has_hi || has_lo))
		else $error("slots not moved into free higher slots");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (has_hi || out_screen[7:4] == '0) && (has_lo || out_screen[3:0] == '0)
			&& (has_ram || out_color == '0))
		else $error("unused slot color not cleared");

	a_cfg_read: assert property (@(posedge clk) disable iff (!arst_n)
		wr_bg ##1 (paddr == '0) |-> prdata[7:0] == $past(pwdata[7:0]))
		else $error("background color readback mismatch");

endmodule

bind multicolor_cell_slot_optimizer mcso_checker u_mcso_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.psel       (psel),
	.penable    (penable),
	.pwrite     (pwrite),
	.paddr      (paddr),
	.pwdata     (pwdata),
	.prdata     (prdata),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_bitmap (out_ch.out_bitmap),
	.out_screen (out_ch.out_screen),
	.out_color  (out_ch.out_color)
);
